// ----- hdl/mrpc_pkg.sv -----
// Shared types and constants for the merged record pair counter.
`default_nettype none

package mrpc_pkg;

  localparam int REC_KEY_W  = 64;
  localparam int COUNT_W    = 10;
  localparam int RPP_W      = 10;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [COUNT_W-1:0]  COUNT_MAX   = '1;
  localparam logic [RPP_W-1:0]    RPP_RESET   = 10'd1;
  localparam logic [CFG_ADDR_W-3:0] REG_RPP_IDX = 1'b0;

  typedef struct packed {
    logic start;
    logic fast;
    logic order_ok;
  } sort_req_t;

  typedef struct packed {
    logic               valid;
    logic               order_ok;
    logic [COUNT_W-1:0] count;
  } sort_res_t;

endpackage

`default_nettype wire

// ----- hdl/mrpc_rec_if.sv -----
// Record channel: valid/ready handshake carrying one input record.
`default_nettype none

interface mrpc_rec_if;
  import mrpc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [REC_KEY_W-1:0] record_key;
  logic                 is_diagnosis;

  modport source (output valid, record_key, is_diagnosis, input ready);
  modport sink   (input valid, record_key, is_diagnosis, output ready);
endinterface

`default_nettype wire

// ----- hdl/mrpc_res_if.sv -----
// Result channel: valid/ready handshake carrying the order flag and pair count.
`default_nettype none

interface mrpc_res_if;
  import mrpc_pkg::*;

  logic               valid;
  logic               ready;
  logic               order_ok;
  logic [COUNT_W-1:0] pair_count;

  modport source (output valid, order_ok, pair_count, input ready);
  modport sink   (input valid, order_ok, pair_count, output ready);
endinterface

`default_nettype wire

// ----- hdl/mrpc_ram.sv -----
// Record memory: one write port, two registered read ports.
`default_nettype none

module mrpc_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 75
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output logic      [DW-1:0] rdata_a,
  output logic      [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ----- hdl/mrpc_load.sv -----
// Record loader: order check, store addressing and sort request.
`default_nettype none

module mrpc_load #(
  parameter int PATIENT_BITS = 32,
  parameter int TIME_BITS    = 32,
  parameter int AW           = 10,
  parameter int CW           = 11
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           restart,
  input  wire logic                           accept,
  input  wire logic [mrpc_pkg::REC_KEY_W-1:0] rec_key,
  input  wire logic                           rec_flag,
  input  wire logic [CW-1:0]                  n_i,
  input  wire logic [CW-1:0]                  total_i,
  output logic                                wr_en,
  output logic [AW-1:0]                       wr_addr,
  output logic [PATIENT_BITS+TIME_BITS+AW:0]  wr_data,
  output mrpc_pkg::sort_req_t                 req
);
  import mrpc_pkg::*;

  localparam int KEY_W = PATIENT_BITS + TIME_BITS;

  logic [AW-1:0]    seen_r, seen_nxt;
  logic             good_r, good_nxt;
  logic             tie_r, tie_nxt;
  logic [KEY_W-1:0] prev_r, prev_nxt;

  logic [KEY_W-1:0] key;
  logic [CW-1:0]    idx_w;
  logic [CW:0]      b_addr;
  logic             last;
  logic             good_upd;
  logic             tie_upd;

  assign key    = rec_key[KEY_W-1:0];
  assign idx_w  = CW'(seen_r);
  assign last   = (idx_w + CW'(1)) == total_i;
  assign b_addr = (CW+1)'(total_i) + (CW+1)'(n_i) - (CW+1)'(1) - (CW+1)'(idx_w);

  always_comb begin
    good_upd = good_r;
    tie_upd  = tie_r;
    if ((idx_w != '0) && (idx_w < n_i)) begin
      if (prev_r > key) good_upd = 1'b0;
    end else if (idx_w > n_i) begin
      if (prev_r < key) good_upd = 1'b0;
      if (prev_r == key) tie_upd = 1'b1;
    end
  end

  always_comb begin
    seen_nxt = seen_r;
    good_nxt = good_r;
    tie_nxt  = tie_r;
    prev_nxt = prev_r;
    if (restart) begin
      seen_nxt = '0;
      good_nxt = 1'b1;
      tie_nxt  = 1'b0;
    end else if (accept) begin
      prev_nxt = key;
      if (last) begin
        seen_nxt = '0;
        good_nxt = 1'b1;
        tie_nxt  = 1'b0;
      end else begin
        seen_nxt = seen_r + AW'(1);
        good_nxt = good_upd;
        tie_nxt  = tie_upd;
      end
    end
  end

  assign wr_en        = accept;
  assign wr_addr      = (idx_w < n_i) ? seen_r : b_addr[AW-1:0];
  assign wr_data      = {key, rec_flag, seen_r};
  assign req.start    = accept && last;
  assign req.fast     = good_upd && !tie_upd;
  assign req.order_ok = good_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      good_r <= 1'b1;
      tie_r  <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
      good_r <= good_nxt;
      tie_r  <= tie_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/mrpc_merge.sv -----
// Merge pass engine: bottom-up stable merge sort between two banks, pair count on the last pass.
`default_nettype none

module mrpc_merge #(
  parameter int PATIENT_BITS = 32,
  parameter int TIME_BITS    = 32,
  parameter int AW           = 10,
  parameter int CW           = 11
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire mrpc_pkg::sort_req_t                 req,
  input  wire logic [CW-1:0]                       n_i,
  input  wire logic [CW-1:0]                       total_i,
  output logic                                     busy,
  output mrpc_pkg::sort_res_t                      res,
  input  wire logic                                res_take,
  output logic [AW-1:0]                            rd_addr_a,
  output logic [AW-1:0]                            rd_addr_b,
  input  wire logic [PATIENT_BITS+TIME_BITS+AW:0]  rd_data_a,
  input  wire logic [PATIENT_BITS+TIME_BITS+AW:0]  rd_data_b,
  output logic                                     src_bank,
  output logic                                     wr_en,
  output logic [AW-1:0]                            wr_addr,
  output logic [PATIENT_BITS+TIME_BITS+AW:0]       wr_data
);
  import mrpc_pkg::*;

  localparam int KEY_W = PATIENT_BITS + TIME_BITS;
  localparam int EW    = KEY_W + 1 + AW;
  localparam int SW    = CW + 2;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PRIME = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  function automatic logic [CW-1:0] clip(input logic [SW-1:0] v, input logic [CW-1:0] lim);
    logic [CW-1:0] r;
    if (v > SW'(lim)) r = lim;
    else r = v[CW-1:0];
    return r;
  endfunction

  logic [1:0]              state_r, state_nxt;
  logic [CW:0]             w_r, w_nxt;
  logic [CW-1:0]           pa_r, pa_nxt;
  logic [CW-1:0]           pb_r, pb_nxt;
  logic [CW-1:0]           ea_r, ea_nxt;
  logic [CW-1:0]           eb_r, eb_nxt;
  logic [CW-1:0]           wp_r, wp_nxt;
  logic [CW-1:0]           tot_r, tot_nxt;
  logic                    src_r, src_nxt;
  logic                    ord_r, ord_nxt;
  logic [COUNT_W-1:0]      cnt_r, cnt_nxt;
  logic                    pvld_r, pvld_nxt;
  logic                    pflag_r, pflag_nxt;
  logic [PATIENT_BITS-1:0] ppat_r, ppat_nxt;

  logic                    avail_a, avail_b, take_a;
  logic [EW-1:0]           head;
  logic [PATIENT_BITS-1:0] head_pat;
  logic [CW:0]             w2, w_first, w_new;
  logic [CW-1:0]           tot_src, ea_new, eb_new, nea, neb;
  logic                    final_pass, blk_last, pass_last, pair_hit;

  assign avail_a  = pa_r < ea_r;
  assign avail_b  = pb_r < eb_r;
  assign take_a   = avail_a && (!avail_b ||
                    ({rd_data_a[EW-1 -: KEY_W], rd_data_a[AW-1:0]} <
                     {rd_data_b[EW-1 -: KEY_W], rd_data_b[AW-1:0]}));
  assign head     = take_a ? rd_data_a : rd_data_b;
  assign head_pat = head[EW-1 -: PATIENT_BITS];

  assign w2         = w_r << 1;
  assign final_pass = w2 >= (CW+1)'(tot_r);
  assign w_first    = req.fast ? (CW+1)'(n_i) : (CW+1)'(1);
  assign w_new      = (state_r == ST_IDLE) ? w_first : w2;
  assign tot_src    = (state_r == ST_IDLE) ? total_i : tot_r;
  assign ea_new     = clip(SW'(w_new), tot_src);
  assign eb_new     = clip(SW'(w_new) << 1, tot_src);
  assign nea        = clip(SW'(eb_r) + SW'(w_r), tot_r);
  assign neb        = clip(SW'(eb_r) + (SW'(w_r) << 1), tot_r);
  assign blk_last   = (wp_r + CW'(1)) == eb_r;
  assign pass_last  = blk_last && (eb_r == tot_r);
  assign pair_hit   = pvld_r && pflag_r && !head[AW] && (ppat_r == head_pat);

  always_comb begin
    state_nxt = state_r;
    w_nxt     = w_r;
    pa_nxt    = pa_r;
    pb_nxt    = pb_r;
    ea_nxt    = ea_r;
    eb_nxt    = eb_r;
    wp_nxt    = wp_r;
    tot_nxt   = tot_r;
    src_nxt   = src_r;
    ord_nxt   = ord_r;
    cnt_nxt   = cnt_r;
    pvld_nxt  = pvld_r;
    pflag_nxt = pflag_r;
    ppat_nxt  = ppat_r;
    case (state_r)
      ST_IDLE: begin
        if (req.start) begin
          state_nxt = ST_PRIME;
          w_nxt     = w_new;
          pa_nxt    = '0;
          ea_nxt    = ea_new;
          pb_nxt    = ea_new;
          eb_nxt    = eb_new;
          wp_nxt    = '0;
          tot_nxt   = total_i;
          src_nxt   = 1'b0;
          ord_nxt   = req.order_ok;
          cnt_nxt   = '0;
          pvld_nxt  = 1'b0;
        end
      end
      ST_PRIME: begin
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        wp_nxt = wp_r + CW'(1);
        if (take_a) pa_nxt = pa_r + CW'(1);
        else pb_nxt = pb_r + CW'(1);
        if (final_pass) begin
          if (pair_hit && (cnt_r != COUNT_MAX)) cnt_nxt = cnt_r + COUNT_W'(1);
          pvld_nxt  = 1'b1;
          pflag_nxt = head[AW];
          ppat_nxt  = head_pat;
        end
        if (pass_last) begin
          if (final_pass) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_PRIME;
            w_nxt     = w_new;
            pa_nxt    = '0;
            ea_nxt    = ea_new;
            pb_nxt    = ea_new;
            eb_nxt    = eb_new;
            wp_nxt    = '0;
            src_nxt   = !src_r;
            pvld_nxt  = 1'b0;
          end
        end else if (blk_last) begin
          pa_nxt = eb_r;
          ea_nxt = nea;
          pb_nxt = nea;
          eb_nxt = neb;
        end
      end
      ST_DONE: begin
        if (res_take) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy         = state_r != ST_IDLE;
  assign res.valid    = state_r == ST_DONE;
  assign res.order_ok = ord_r;
  assign res.count    = cnt_r;
  assign rd_addr_a    = pa_nxt[AW-1:0];
  assign rd_addr_b    = pb_nxt[AW-1:0];
  assign src_bank     = src_r;
  assign wr_en        = state_r == ST_RUN;
  assign wr_addr      = wp_r[AW-1:0];
  assign wr_data      = head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r     <= w_nxt;
    pa_r    <= pa_nxt;
    pb_r    <= pb_nxt;
    ea_r    <= ea_nxt;
    eb_r    <= eb_nxt;
    wp_r    <= wp_nxt;
    tot_r   <= tot_nxt;
    src_r   <= src_nxt;
    ord_r   <= ord_nxt;
    cnt_r   <= cnt_nxt;
    pvld_r  <= pvld_nxt;
    pflag_r <= pflag_nxt;
    ppat_r  <= ppat_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/merged_record_pair_count_top.sv -----
// Merged record pair counter: loads two parties of records, sorts them, counts pairs.
// Each batch is 2n records, n taken from the records_per_party register (0 acts as 1, larger
// than MAX_PER_PARTY acts as MAX_PER_PARTY). Records are taken one per cycle;
// the last record of a batch starts the sort and in_rec.ready stays low until the result is
// handed to the output register. The sort runs merge passes between two record banks; the
// merge unit reads both run heads and writes one record per cycle. One pass suffices when
// the first party never decreases and the second party strictly decreases; otherwise
// ceil(log2(2n)) passes run. The pair count is formed during the last pass; the result then
// waits until the output register is free, moves into it and waits there for out_res.ready
// while the next batch loads. A register write abandons a batch still loading; the user must
// write the register only while the block is idle, as the block does not enforce it.
`default_nettype none

module merged_record_pair_count_top #(
  parameter int MAX_PER_PARTY = 512,
  parameter int PATIENT_BITS  = 32,
  parameter int TIME_BITS     = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  mrpc_rec_if.sink                              in_rec,
  mrpc_res_if.source                            out_res,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mrpc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [mrpc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [mrpc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                  pready
);
  import mrpc_pkg::*;

  localparam int DEPTH = 2 * MAX_PER_PARTY;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int EW    = PATIENT_BITS + TIME_BITS + 1 + AW;

  logic [RPP_W-1:0]   rpp_r, rpp_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [COUNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic          reg_sel, cfg_wr, accept, res_take;
  logic [CW-1:0] n_val, total;

  sort_req_t     req;
  sort_res_t     res;
  logic          eng_busy, eng_src, eng_we;
  logic [AW-1:0] eng_ra, eng_rb, eng_wa;
  logic [EW-1:0] eng_wd;
  logic          ld_we;
  logic [AW-1:0] ld_wa;
  logic [EW-1:0] ld_wd;

  logic          b0_we, b1_we;
  logic [AW-1:0] b0_wa;
  logic [EW-1:0] b0_wd;
  logic [EW-1:0] rd0_a, rd0_b, rd1_a, rd1_b, rd_a, rd_b;

  assign reg_sel = paddr[CFG_ADDR_W-1:2] == REG_RPP_IDX;
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? CFG_DATA_W'(rpp_r) : '0;
  assign rpp_nxt = cfg_wr ? pwdata[RPP_W-1:0] : rpp_r;

  always_comb begin
    if (rpp_r == '0) n_val = CW'(1);
    else if (32'(rpp_r) > 32'(MAX_PER_PARTY)) n_val = CW'(MAX_PER_PARTY);
    else n_val = CW'(rpp_r);
  end
  assign total = n_val << 1;

  assign in_rec.ready = !eng_busy;
  assign accept       = in_rec.valid && !eng_busy;

  mrpc_load #(
    .PATIENT_BITS (PATIENT_BITS),
    .TIME_BITS    (TIME_BITS),
    .AW           (AW),
    .CW           (CW)
  ) u_load (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (cfg_wr),
    .accept   (accept),
    .rec_key  (in_rec.record_key),
    .rec_flag (in_rec.is_diagnosis),
    .n_i      (n_val),
    .total_i  (total),
    .wr_en    (ld_we),
    .wr_addr  (ld_wa),
    .wr_data  (ld_wd),
    .req      (req)
  );

  mrpc_merge #(
    .PATIENT_BITS (PATIENT_BITS),
    .TIME_BITS    (TIME_BITS),
    .AW           (AW),
    .CW           (CW)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .n_i       (n_val),
    .total_i   (total),
    .busy      (eng_busy),
    .res       (res),
    .res_take  (res_take),
    .rd_addr_a (eng_ra),
    .rd_addr_b (eng_rb),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b),
    .src_bank  (eng_src),
    .wr_en     (eng_we),
    .wr_addr   (eng_wa),
    .wr_data   (eng_wd)
  );

  assign b0_we = ld_we || (eng_we && eng_src);
  assign b0_wa = ld_we ? ld_wa : eng_wa;
  assign b0_wd = ld_we ? ld_wd : eng_wd;
  assign b1_we = eng_we && !eng_src;
  assign rd_a  = eng_src ? rd1_a : rd0_a;
  assign rd_b  = eng_src ? rd1_b : rd0_b;

  mrpc_ram #(.DEPTH(DEPTH), .AW(AW), .DW(EW)) u_bank0 (
    .clk     (clk),
    .we      (b0_we),
    .waddr   (b0_wa),
    .wdata   (b0_wd),
    .raddr_a (eng_ra),
    .raddr_b (eng_rb),
    .rdata_a (rd0_a),
    .rdata_b (rd0_b)
  );

  mrpc_ram #(.DEPTH(DEPTH), .AW(AW), .DW(EW)) u_bank1 (
    .clk     (clk),
    .we      (b1_we),
    .waddr   (eng_wa),
    .wdata   (eng_wd),
    .raddr_a (eng_ra),
    .raddr_b (eng_rb),
    .rdata_a (rd1_a),
    .rdata_b (rd1_b)
  );

  assign res_take = res.valid && (!out_valid_r || out_res.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_cnt_nxt   = out_cnt_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = res.order_ok;
      out_cnt_nxt   = res.count;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.order_ok   = out_ok_r;
  assign out_res.pair_count = out_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpp_r       <= RPP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      rpp_r       <= rpp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r  <= out_ok_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

endmodule

`default_nettype wire

// ----- hdl/mrpc_check.sv -----
// Port-level assertions for the merged record pair counter, bound to the top level.
`default_nettype none

module mrpc_check (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         out_order_ok,
  input wire logic [mrpc_pkg::COUNT_W-1:0] out_pair_count
);
  import mrpc_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result appeared right after an accepted record");

  a_sort_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |=> !in_ready)
    else $error("input reopened too early after the last record");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_order_ok) && $stable(out_pair_count))
    else $error("result changed while stalled");

endmodule

bind merged_record_pair_count_top mrpc_check u_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_rec.valid),
  .in_ready       (in_rec.ready),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .out_order_ok   (out_res.order_ok),
  .out_pair_count (out_res.pair_count)
);

`default_nettype wire

// ----- tb/sv/merged_record_pair_count_top_tb.sv -----
// Testbench for the merged record pair counter: directed and random record batches checked against a predictor.
`default_nettype none

module merged_record_pair_count_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mrpc_pkg::*;

  localparam int MAX_PER_PARTY  = 512;
  localparam int PATIENT_BITS   = 32;
  localparam int TIME_BITS      = 32;
  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 11;
  localparam int TAIL_CYCLES    = 64;
  localparam int LONG_HOLD      = 3000;
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int NUM_PHASES     = 10;

  localparam logic [CFG_ADDR_W-1:0] RPP_ADDR = {REG_RPP_IDX, 2'b00};

  typedef struct packed {
    logic               order_ok;
    logic [COUNT_W-1:0] pair_count;
  } tally_t;

  class pair_count_board;
    logic [RPP_W-1:0]     party_reg;
    logic [REC_KEY_W-1:0] batch_keys[$];
    logic                 batch_flags[$];
    logic                 order_good;
    logic [REC_KEY_W-1:0] last_key;
    tally_t               expected_tallies[$];
    int                   errors;

    function new();
      party_reg = RPP_RESET;
      errors    = 0;
      restart();
    endfunction

    function void restart();
      batch_keys.delete();
      batch_flags.delete();
      order_good = 1'b1;
      last_key   = '0;
    endfunction

    function int party_size();
      if (party_reg == 0) return 1;
      if (party_reg > MAX_PER_PARTY) return MAX_PER_PARTY;
      return int'(party_reg);
    endfunction

    function void set_party_reg(logic [CFG_DATA_W-1:0] value);
      party_reg = value[RPP_W-1:0];
      restart();
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    function tally_t count_pairs();
      logic [REC_KEY_W-1:0] k[$];
      logic                 f[$];
      logic [REC_KEY_W-1:0] kv;
      logic                 fv;
      int                   j;
      int unsigned          pairs;
      tally_t               t;
      k = batch_keys;
      f = batch_flags;
      for (int i = 1; i < k.size(); i++) begin
        kv = k[i];
        fv = f[i];
        j = i;
        while (j > 0 && k[j-1] > kv) begin
          k[j] = k[j-1];
          f[j] = f[j-1];
          j--;
        end
        k[j] = kv;
        f[j] = fv;
      end
      pairs = 0;
      for (int i = 0; i + 1 < k.size(); i++) begin
        if (f[i] && !f[i+1] &&
            k[i][TIME_BITS +: PATIENT_BITS] == k[i+1][TIME_BITS +: PATIENT_BITS] &&
            pairs < COUNT_MAX)
          pairs++;
      end
      t.order_ok   = order_good;
      t.pair_count = pairs[COUNT_W-1:0];
      return t;
    endfunction

    function void note_record(logic [REC_KEY_W-1:0] key, logic flag);
      int n;
      int idx;
      n   = party_size();
      idx = batch_keys.size();
      if (idx >= 1 && idx < n) begin
        if (last_key > key) order_good = 1'b0;
      end else if (idx > n) begin
        if (last_key < key) order_good = 1'b0;
      end
      batch_keys.push_back(key);
      batch_flags.push_back(flag);
      last_key = key;
      if (batch_keys.size() == 2 * n) begin
        expected_tallies.push_back(count_pairs());
        restart();
      end
    endfunction

    task check_result(logic order_ok, logic [COUNT_W-1:0] pair_count);
      tally_t want;
      if (expected_tallies.size() == 0) begin
        report($sformatf("unexpected result order_ok=%0b pair_count=%0d", order_ok, pair_count));
      end else begin
        want = expected_tallies.pop_front();
        if (order_ok !== want.order_ok)
          report($sformatf("order_ok got %0b want %0b", order_ok, want.order_ok));
        if (pair_count !== want.pair_count)
          report($sformatf("pair_count got %0d want %0d", pair_count, want.pair_count));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  mrpc_rec_if rec_ch ();
  mrpc_res_if res_ch ();

  merged_record_pair_count_top #(
    .MAX_PER_PARTY(MAX_PER_PARTY),
    .PATIENT_BITS (PATIENT_BITS),
    .TIME_BITS    (TIME_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_rec (rec_ch.sink),
    .out_res(res_ch.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  pair_count_board board = new();

  logic source_idle = 1'b1;
  logic sink_idle   = 1'b1;
  logic long_hold   = 1'b0;

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("** merged_record_pair_count_top: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (rec_ch.valid && rec_ch.ready)
        board.note_record(rec_ch.record_key, rec_ch.is_diagnosis);
      if (res_ch.valid && res_ch.ready)
        board.check_result(res_ch.order_ok, res_ch.pair_count);
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        stall = sink_idle ? gap_len() : 0;
        if (stall > 0) begin
          res_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == RPP_ADDR) board.set_party_reg(data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_W-1:0] rpp_word(int unsigned value, logic noisy);
    logic [CFG_DATA_W-1:0] w;
    w = noisy ? CFG_DATA_W'($urandom) : '0;
    w[RPP_W-1:0] = value[RPP_W-1:0];
    return w;
  endfunction

  task automatic send_record(input logic [REC_KEY_W-1:0] key, input logic flag);
    int gap;
    gap = source_idle ? gap_len() : 0;
    if (gap > 0) begin
      rec_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rec_ch.valid        <= 1'b1;
    rec_ch.record_key   <= key;
    rec_ch.is_diagnosis <= flag;
    @(posedge clk);
    while (!rec_ch.ready) @(posedge clk);
  endtask

  task automatic hold_and_drain();
    rec_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.expected_tallies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [REC_KEY_W-1:0] pick_key(ref logic [PATIENT_BITS-1:0] pool[$]);
    logic [TIME_BITS-1:0] ts;
    case ($urandom_range(0, 5))
      0:       ts = '0;
      1:       ts = '1;
      2:       ts = TIME_BITS'($urandom);
      default: ts = TIME_BITS'($urandom_range(0, 5));
    endcase
    return {pool[$urandom_range(0, pool.size() - 1)], ts};
  endfunction

  task automatic send_batch(input int n);
    logic [PATIENT_BITS-1:0] pool[$];
    logic [REC_KEY_W-1:0]    a[$];
    logic [REC_KEY_W-1:0]    b[$];
    logic [REC_KEY_W-1:0]    tmp;
    int                      style;
    int                      i;
    int                      j;
    style = $urandom_range(0, 99);
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 3))
        0:       pool.push_back('0);
        1:       pool.push_back('1);
        default: pool.push_back(PATIENT_BITS'($urandom));
      endcase
    end
    for (int k = 0; k < n; k++) begin
      if (style >= 85) begin
        a.push_back({$urandom, $urandom});
        b.push_back({$urandom, $urandom});
      end else begin
        a.push_back(pick_key(pool));
        b.push_back(pick_key(pool));
      end
    end
    if (style < 85) begin
      a.sort();
      b.rsort();
    end
    if (style >= 70 && style < 85) begin
      i = $urandom_range(0, n - 1);
      j = $urandom_range(0, n - 1);
      tmp = a[i]; a[i] = a[j]; a[j] = tmp;
      i = $urandom_range(0, n - 1);
      j = $urandom_range(0, n - 1);
      tmp = b[i]; b[i] = b[j]; b[j] = tmp;
    end
    foreach (a[k]) send_record(a[k], 1'($urandom_range(0, 1)));
    foreach (b[k]) send_record(b[k], 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int unsigned phase_value[NUM_PHASES];
    int          phase_batches[NUM_PHASES];
    phase_value         = '{1, 2, 3, 0, 5, 8, 16, 7, 100, 1};
    phase_batches       = '{20, 12, 8, 10, 4, 3, 2, 4, 1, 30};
    rst_n               <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    rec_ch.valid        <= 1'b0;
    rec_ch.record_key   <= '0;
    rec_ch.is_diagnosis <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_record(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_record(64'h0000_0000_0000_0000, 1'b0);
    send_record(64'h0000_0001_0000_0005, 1'b1);
    send_record(64'h0000_0001_0000_0005, 1'b0);
    send_record(64'h0000_0001_0000_0005, 1'b0);
    send_record(64'h0000_0001_0000_0005, 1'b1);
    hold_and_drain();

    cfg_write(RPP_ADDR, 32'hFFFF_FC00);
    send_record(64'h5555_5555_AAAA_AAAA, 1'b1);
    send_record(64'hAAAA_AAAA_5555_5555, 1'b0);
    hold_and_drain();

    cfg_write(RPP_ADDR, rpp_word(3, 1'b0));
    send_record(64'h0000_0007_0000_0001, 1'b1);
    send_record(64'h0000_0007_0000_0003, 1'b1);
    send_record(64'h0000_0007_0000_0002, 1'b0);
    send_record(64'h0000_0007_0000_0009, 1'b0);
    send_record(64'h0000_0007_0000_0004, 1'b1);
    send_record(64'h0000_0007_0000_0004, 1'b0);
    send_record(64'h0000_0002_0000_0001, 1'b1);
    send_record(64'h0000_0002_0000_0002, 1'b0);
    send_record(64'h0000_0009_0000_0000, 1'b1);
    send_record(64'h0000_0005_0000_0000, 1'b0);
    send_record(64'h0000_0004_0000_0000, 1'b1);
    send_record(64'h0000_0002_0000_0003, 1'b0);
    send_record(64'h0000_0003_0000_0000, 1'b1);
    send_record(64'h0000_0003_0000_0001, 1'b0);
    hold_and_drain();

    cfg_write(RPP_ADDR, rpp_word(1023, 1'b0));
    send_record(64'h0000_0003_0000_0002, 1'b1);
    send_record(64'h0000_0003_0000_0003, 1'b0);
    hold_and_drain();
    cfg_write(RPP_ADDR, rpp_word(1, 1'b0));
    send_record(64'h0000_0003_0000_0000, 1'b1);
    send_record(64'h0000_0003_0000_0000, 1'b0);
    hold_and_drain();

    phase_value[7] = $urandom_range(1, 12);
    for (int p = 0; p < NUM_PHASES; p++) begin
      source_idle = ($urandom_range(0, 3) != 0);
      sink_idle   = ($urandom_range(0, 3) != 0);
      cfg_write(RPP_ADDR, rpp_word(phase_value[p], p == 3 || $urandom_range(0, 2) == 0));
      if (p == NUM_PHASES - 1) begin
        source_idle = 1'b0;
        long_hold   = 1'b1;
      end
      for (int bt = 0; bt < phase_batches[p]; bt++) begin
        send_batch(board.party_size());
        if (p == 1 && bt == phase_batches[p] / 2) hold_and_drain();
      end
      hold_and_drain();
    end

    if (board.errors == 0) begin
      $display("** merged_record_pair_count_top: PASSED **");
    end else begin
      $display("** merged_record_pair_count_top: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
